// File: rtl/cmgc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the colour matrix and gamma pipeline.
// No dependencies; used by cmgc_row_mac and the top level.
package cmgc_pkg;

    localparam int DEF_CURVE_DEPTH    = 1024;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam int CODE_W    = 10;  // pixel code and table index width
    localparam int VAL_W     = 16;  // table write data width
    localparam int LIN_W     = 16;  // unsigned 10.6 linear value
    localparam int COEF_W    = 16;  // one signed matrix coefficient
    localparam int ROW_W     = 3 * COEF_W;
    localparam int PROD_W    = COEF_W + LIN_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int IDX_CMP_W = 13;  // wide enough for any supported table depth
    localparam int CH_N      = 3;
    localparam int DATA_IN_W  = 56;
    localparam int DATA_OUT_W = 32;
    localparam int USER_W     = 2;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [USER_W-1:0] {
        MODE_PIXEL = 2'd0,
        MODE_PRE   = 2'd1,
        MODE_POST  = 2'd2
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BLUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 2'd3;

    localparam logic [ROW_W-1:0] RST_COEF_RED   = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] RST_COEF_GREEN = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] RST_COEF_BLUE  = 48'h1000_0000_0000;

    // Load enables of the two arithmetic stages inside one matrix row.
    typedef struct packed {
        logic load2;
        logic load3;
    } t_mac_en;

endpackage

// File: rtl/cmgc_curve_ram.sv
`timescale 1ns / 1ps
// Single write port, single read port curve table with registered read data.
// Depends on nothing outside this file.
module cmgc_curve_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cmgc_row_mac.sv
`timescale 1ns / 1ps
// One matrix row: three coefficient products, then their rounded sum.
// Depends on cmgc_pkg.
module cmgc_row_mac
    import cmgc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  t_mac_en                 i_en,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [LIN_W-1:0]        i_lin [CH_N],
    output logic signed [SUM_W-1:0] o_sum
);

    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_prod [CH_N];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CH_N; j++) begin
            if (i_en.load2) begin
                r_prod[j] <= $signed(i_row[j*COEF_W +: COEF_W])
                             * $signed({1'b0, i_lin[j]});
            end
        end
    end

    always_comb begin
        n_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]) + ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load3) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: rtl/color_matrix_gamma_convert_core.sv
`timescale 1ns / 1ps
// Top level of the colour matrix and gamma pipeline.
// Depends on cmgc_pkg, cmgc_curve_ram and cmgc_row_mac.
//
// Usage:
//   The slave stream carries one transaction per pixel or table write. tuser holds the
//   mode: pixel, pre-curve table write or post-curve table write. tdata holds red, green,
//   blue, the table index and the table value. Only pixels produce a transaction on the
//   master stream, whose tdata holds the three corrected 10-bit codes.
//   The configuration port writes one coefficient row or the bypass flag per write, chosen
//   by the index; it is only to be used while the pipeline is empty.
//   Pipeline: the accepting edge loads the pre-curve read stage; the multiply, sum, clamp
//   and post-curve read, and output register stages follow. Throughput is one transaction
//   per cycle while the master side keeps tready high.
//   Each stage has its own valid bit and loads whenever it is empty or its successor
//   loads, so a stalled receiver backs up the pipeline stage by stage and bubbles are
//   squeezed out; slave tready falls only once every stage is full.
//   Reset clears all valid bits, restores the identity matrix and sets bypass. The curve
//   tables are not cleared and must be loaded before bypass is switched off.
module color_matrix_gamma_convert_core
    import cmgc_pkg::*;
#(
    parameter int CURVE_DEPTH    = DEF_CURVE_DEPTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: red[9:0], green[19:10], blue[29:20], table_index[39:30], table_value[55:40]
    input  logic [DATA_IN_W-1:0]  i_s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [USER_W-1:0]     i_s_axis_tuser,
    // Master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: out_red[9:0], out_green[19:10], out_blue[29:20], zero[31:30]
    output logic [DATA_OUT_W-1:0] o_m_axis_tdata,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ROW_W-1:0]      i_cfg_wdata
);

    localparam int AW = $clog2(CURVE_DEPTH);

    // Saturating table address: anything at or beyond the depth reads the last entry.
    function automatic logic [AW-1:0] f_clip(input logic [IDX_CMP_W-1:0] v);
        logic [AW-1:0] res;
        if (v >= IDX_CMP_W'(CURVE_DEPTH)) begin
            res = AW'(CURVE_DEPTH - 1);
        end else begin
            res = v[AW-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic [ROW_W-1:0] r_coef [CH_N];
    logic             r_bypass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= RST_COEF_RED;
            r_coef[1] <= RST_COEF_GREEN;
            r_coef[2] <= RST_COEF_BLUE;
            r_bypass  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COEF_RED:   r_coef[0] <= i_cfg_wdata;
                REG_COEF_GREEN: r_coef[1] <= i_cfg_wdata;
                REG_COEF_BLUE:  r_coef[2] <= i_cfg_wdata;
                REG_BYPASS:     r_bypass  <= i_cfg_wdata[0];
            endcase
        end
    end

    // Input unpacking
    t_mode              w_mode;
    logic [CODE_W-1:0]  w_code [CH_N];
    logic [CODE_W-1:0]  w_idx;
    logic [VAL_W-1:0]   w_val;
    logic               w_idx_ok;
    logic               w_accept;
    logic               w_pre_we;

    assign w_mode    = t_mode'(i_s_axis_tuser);
    assign w_code[0] = i_s_axis_tdata[9:0];
    assign w_code[1] = i_s_axis_tdata[19:10];
    assign w_code[2] = i_s_axis_tdata[29:20];
    assign w_idx     = i_s_axis_tdata[39:30];
    assign w_val     = i_s_axis_tdata[55:40];
    assign w_idx_ok  = IDX_CMP_W'(w_idx) < IDX_CMP_W'(CURVE_DEPTH);

    // Stage valid bits and load enables; each stage loads when empty or draining.
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;
    logic r_s1_pix, r_s2_pix, r_s3_pix, r_s4_pix;
    logic w_load1, w_load2, w_load3, w_load4, w_load_out;

    assign w_load_out = !r_out_vld || i_m_axis_tready;
    assign w_load4    = !r_s4_vld  || w_load_out;
    assign w_load3    = !r_s3_vld  || w_load4;
    assign w_load2    = !r_s2_vld  || w_load3;
    assign w_load1    = !r_s1_vld  || w_load2;

    assign o_s_axis_tready = w_load1;
    assign w_accept        = i_s_axis_tvalid && w_load1;

    // Pre-curve writes happen at acceptance, so later pixels see them at once.
    assign w_pre_we = w_accept && (w_mode == MODE_PRE) && w_idx_ok;

    // Stage 1: pre-curve read. Post-curve writes travel along to the post-curve read stage
    // so that they stay ordered against pixels already in flight.
    logic [CODE_W-1:0] r_s1_code [CH_N];
    logic [AW-1:0]     r_s1_idx, r_s2_idx, r_s3_idx;
    logic [CODE_W-1:0] r_s1_val, r_s2_val, r_s3_val;
    logic [LIN_W-1:0]  w_pre_q [CH_N];
    logic [LIN_W-1:0]  w_lin [CH_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_load1) begin
            r_s1_vld <= w_accept && ((w_mode == MODE_PIXEL)
                                     || ((w_mode == MODE_POST) && w_idx_ok));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_s1_pix  <= w_mode == MODE_PIXEL;
            r_s1_code <= w_code;
            r_s1_idx  <= f_clip(IDX_CMP_W'(w_idx));
            r_s1_val  <= w_val[CODE_W-1:0];
        end
    end

    // Stage 2 and 3: products, then rounded sums, inside the row units.
    t_mac_en                 w_mac_en;
    logic signed [SUM_W-1:0] w_sum [CH_N];

    assign w_mac_en.load2 = w_load2;
    assign w_mac_en.load3 = w_load3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_load2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_load3) begin
                r_s3_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_s2_pix <= r_s1_pix;
            r_s2_idx <= r_s1_idx;
            r_s2_val <= r_s1_val;
        end
        if (w_load3) begin
            r_s3_pix <= r_s2_pix;
            r_s3_idx <= r_s2_idx;
            r_s3_val <= r_s2_val;
        end
    end

    // Stage 4: clamp to 10.6, take the integer part and read the post-curve table.
    logic [CODE_W-1:0] w_ip [CH_N];
    logic [CODE_W-1:0] r_s4_ip [CH_N];
    logic [CODE_W-1:0] w_post_q [CH_N];
    logic              w_post_we;

    assign w_post_we = r_s3_vld && !r_s3_pix && w_load4;

    always_comb begin
        logic signed [SUM_W-1:0] sh;
        logic [LIN_W-1:0]        clamped;
        for (int c = 0; c < CH_N; c++) begin
            sh = w_sum[c] >>> COEF_FRAC_BITS;
            if (w_sum[c][SUM_W-1]) begin
                clamped = '0;
            end else if (|sh[SUM_W-2:LIN_W]) begin
                clamped = '1;
            end else begin
                clamped = sh[LIN_W-1:0];
            end
            w_ip[c] = clamped[LIN_W-1:6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_load4) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load4) begin
            r_s4_pix <= r_s3_pix;
            r_s4_ip  <= w_ip;
        end
    end

    for (genvar c = 0; c < CH_N; c++) begin : g_ch
        assign w_lin[c] = r_bypass ? {r_s1_code[c], 6'b0} : w_pre_q[c];

        cmgc_curve_ram #(
            .DEPTH (CURVE_DEPTH),
            .WIDTH (LIN_W)
        ) u_pre_ram (
            .i_clk   (i_clk),
            .i_we    (w_pre_we),
            .i_waddr (f_clip(IDX_CMP_W'(w_idx))),
            .i_wdata (w_val),
            .i_re    (w_load1),
            .i_raddr (f_clip(IDX_CMP_W'(w_code[c]))),
            .o_rdata (w_pre_q[c])
        );

        cmgc_row_mac #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_row_mac (
            .i_clk (i_clk),
            .i_en  (w_mac_en),
            .i_row (r_coef[c]),
            .i_lin (w_lin),
            .o_sum (w_sum[c])
        );

        cmgc_curve_ram #(
            .DEPTH (CURVE_DEPTH),
            .WIDTH (CODE_W)
        ) u_post_ram (
            .i_clk   (i_clk),
            .i_we    (w_post_we),
            .i_waddr (r_s3_idx),
            .i_wdata (r_s3_val),
            .i_re    (w_load4),
            .i_raddr (f_clip(IDX_CMP_W'(w_ip[c]))),
            .o_rdata (w_post_q[c])
        );
    end

    // Output register: only pixels leave the block.
    logic [CODE_W-1:0] r_out [CH_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= r_s4_vld && r_s4_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            for (int c = 0; c < CH_N; c++) begin
                r_out[c] <= r_bypass ? r_s4_ip[c] : w_post_q[c];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b0, r_out[2], r_out[1], r_out[0]};

    // The slave side is held off only when the first stage is occupied.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_s1_vld)
        else $error("slave tready low with an empty first stage");

    // An item in stage four is never dropped while the output is blocked.
    a_s4_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_vld && !w_load4) |=> r_s4_vld)
        else $error("stage four item lost during a stall");

    // Reset leaves no transaction on the master side.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("master tvalid high after reset");

endmodule
